[rtl/efpu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpu_pkg
// Types, codes and helpers shared by the extended float fast-path unit.
// ----------------------------------------------------------------------------
package efpu_pkg;

    // Input kinds
    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_CVS = 3'd3;
    localparam logic [2:0] KIND_CVD = 3'd4;

    // Internal operation classes decided by the front end
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_MUL   = 3'd1;
    localparam logic [2:0] OP_CVS   = 3'd2;
    localparam logic [2:0] OP_CVD   = 3'd3;
    localparam logic [2:0] OP_ZERO  = 3'd4;
    localparam logic [2:0] OP_DEFER = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_RC = 2'd0;
    localparam logic [1:0] CFG_PC = 2'd1;

    // Rounding control
    localparam logic [1:0] RC_NEAR  = 2'd0;
    localparam logic [1:0] RC_DOWN  = 2'd1;
    localparam logic [1:0] RC_UP    = 2'd2;

    // Precision control
    localparam logic [1:0] PC_SINGLE = 2'd0;
    localparam logic [1:0] PC_RSVD   = 2'd1;
    localparam logic [1:0] PC_DOUBLE = 2'd2;
    localparam logic [1:0] PC_EXT    = 2'd3;

    localparam logic [14:0] EXP_MAX  = 15'h7FFF;
    localparam logic [17:0] EXP_TOP  = 18'h07FFD;
    localparam logic [17:0] MUL_BIAS = 18'h03FFE;
    localparam logic [63:0] TOP64    = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] a_significand;
        logic [15:0] a_sign_exponent;
        logic [63:0] b_significand;
        logic [15:0] b_sign_exponent;
    } item_t;

    typedef struct packed {
        logic        deferred;
        logic [63:0] result_significand;
        logic [15:0] result_sign_exponent;
    } result_t;

    // Classified command passed from front end to back end
    typedef struct packed {
        logic [2:0]  op;
        logic        sub;
        logic        sign;
        logic [17:0] exp;
        logic [5:0]  shift;
        logic [63:0] x;
        logic [63:0] y;
    } cmd_t;

    // Leading zeros of a 128-bit word by binary search, 128 when zero
    function automatic logic [7:0] lead_zeros128(input logic [127:0] v);
        logic [127:0] t;
        logic [7:0]   n;
        int           k;
        t = v;
        n = '0;
        if (v == '0)
        begin
            n = 8'd128;
        end
        else
        begin
            for (k = 6; k >= 0; k--)
            begin
                if ((t >> (128 - (1 << k))) == '0)
                begin
                    n = n + 8'(1 << k);
                    t = t << (1 << k);
                end
            end
        end
        return n;
    endfunction

endpackage

[rtl/efpu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpu_front
// Accepts transactions, checks operands and orders them for the back end.
// ----------------------------------------------------------------------------
module efpu_front (
    input  logic           start,
    input  logic           full,
    input  efpu_pkg::item_t item,
    output logic           busy,
    output logic           push,
    output efpu_pkg::cmd_t cmd
);
    import efpu_pkg::*;

    logic [14:0] ea, eb;
    logic        bs, a_ok, b_ok, neg, gap, swap, sub;
    logic [15:0] diff, mag;

    assign busy = full;
    assign push = start && !full;

    // operand checks and exponent gap
    always_comb
    begin
        ea   = item.a_sign_exponent[14:0];
        eb   = item.b_sign_exponent[14:0];
        bs   = item.b_sign_exponent[15] ^ (item.kind == KIND_SUB);
        a_ok = (ea != '0) && (ea != EXP_MAX) && item.a_significand[63];
        b_ok = (eb != '0) && (eb != EXP_MAX) && item.b_significand[63];
        diff = {1'b0, ea} - {1'b0, eb};
        neg  = diff[15];
        mag  = neg ? (16'd0 - diff) : diff;
        gap  = (mag > 16'd63);
        swap = neg || ((diff == '0) && (item.b_significand > item.a_significand));
        sub  = item.a_sign_exponent[15] ^ bs;
    end

    // classification
    always_comb
    begin
        cmd = '0;
        case (item.kind)
            KIND_ADD, KIND_SUB:
            begin
                if (!a_ok || !b_ok || gap)
                    cmd.op = OP_DEFER;
                else if (sub && (diff == '0) && (item.a_significand == item.b_significand))
                    cmd.op = OP_ZERO;
                else
                begin
                    cmd.op    = OP_ADD;
                    cmd.sub   = sub;
                    cmd.sign  = item.a_sign_exponent[15] ^ (swap & sub);
                    cmd.exp   = {3'b0, (swap ? eb : ea)};
                    cmd.shift = mag[5:0];
                    cmd.x     = swap ? item.b_significand : item.a_significand;
                    cmd.y     = swap ? item.a_significand : item.b_significand;
                end
            end
            KIND_MUL:
            begin
                if (!a_ok || !b_ok)
                    cmd.op = OP_DEFER;
                else
                begin
                    cmd.op   = OP_MUL;
                    cmd.sign = item.a_sign_exponent[15] ^ item.b_sign_exponent[15];
                    cmd.exp  = {3'b0, ea} + {3'b0, eb} - MUL_BIAS;
                    cmd.x    = item.a_significand;
                    cmd.y    = item.b_significand;
                end
            end
            KIND_CVS, KIND_CVD:
            begin
                cmd.op   = (item.kind == KIND_CVS) ? OP_CVS : OP_CVD;
                cmd.sign = item.a_sign_exponent[15];
                cmd.exp  = {3'b0, ea};
                cmd.x    = item.a_significand;
            end
            default:
            begin
                cmd.op = OP_DEFER;
            end
        endcase
    end

endmodule

[rtl/efpu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpu_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module efpu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  efpu_pkg::cmd_t push_data,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output efpu_pkg::cmd_t head
);
    import efpu_pkg::*;

    cmd_t       slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] fill;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = slot0_reg;

    // shift on pop, write behind the remaining entries
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        fill       = count_reg;
        if (pop && valid)
        begin
            slot0_next = slot1_reg;
            fill       = count_reg - 2'd1;
        end
        if (push)
        begin
            if (fill == 2'd0)
                slot0_next = push_data;
            else
                slot1_next = push_data;
        end
        count_next = fill + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[rtl/efpu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpu_back
// Four-stage datapath: align/add or partial products, sum and count,
// normalize, round and pack.
// ----------------------------------------------------------------------------
module efpu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  efpu_pkg::cmd_t   cmd,
    input  logic [1:0]       rc,
    input  logic [1:0]       pc,
    output logic             done,
    output efpu_pkg::result_t result
);
    import efpu_pkg::*;

    // ---------------- stage 1 ----------------
    logic         s1_valid_reg, s1_fin_reg, s1_mul_reg, s1_sign_reg;
    result_t      s1_res_reg, s1_res_next;
    logic [127:0] s1_v_reg, s1_v_next;
    logic [63:0]  s1_p01_reg, s1_p10_reg;
    logic [17:0]  s1_exp_reg, s1_exp_next;
    logic         s1_fin_next;

    logic [127:0] sh;
    logic [128:0] s129;
    logic [63:0]  val, cinc, csum, csig, cbits, chalf, cpack;
    logic [14:0]  cexp;
    logic         crange, caway;

    always_comb
    begin
        s1_res_next = '0;
        s1_fin_next = 1'b1;
        s1_v_next   = {({32'b0, cmd.y[63:32]} * {32'b0, cmd.x[63:32]}),
                       ({32'b0, cmd.y[31:0]} * {32'b0, cmd.x[31:0]})};
        s1_exp_next = cmd.exp;
        sh          = {cmd.y, 64'b0} >> cmd.shift;
        s129        = cmd.sub ? ({1'b0, cmd.x, 64'b0} - {1'b0, sh})
                              : ({1'b0, cmd.x, 64'b0} + {1'b0, sh});
        caway       = cmd.sign ? (rc == RC_DOWN) : (rc == RC_UP);
        // conversion window and rounding position
        if (cmd.op == OP_CVD)
        begin
            val    = {1'b0, cmd.x[63:1]} | {63'b0, cmd.x[0]};
            cexp   = cmd.exp[14:0] - 15'h3C01;
            crange = (cmd.exp[14:0] >= 15'h3C01) && (cexp <= 15'h07FC);
            chalf  = 64'h200;
            cinc   = (rc == RC_NEAR) ? chalf : (caway ? 64'h3FF : 64'h0);
            cbits  = val & 64'h3FF;
            csum   = val + cinc;
            csig   = csum >> 10;
        end
        else
        begin
            val    = {33'b0, cmd.x[63:33]} | {63'b0, (cmd.x[32:0] != '0)};
            cexp   = cmd.exp[14:0] - 15'h3F81;
            crange = (cmd.exp[14:0] >= 15'h3F81) && (cexp <= 15'h00FC);
            chalf  = 64'h40;
            cinc   = (rc == RC_NEAR) ? chalf : (caway ? 64'h7F : 64'h0);
            cbits  = val & 64'h7F;
            csum   = val + cinc;
            csig   = csum >> 7;
        end
        if ((rc == RC_NEAR) && (cbits == chalf))
            csig[0] = 1'b0;
        if (csig == '0)
            cexp = '0;
        if (cmd.op == OP_CVD)
            cpack = {cmd.sign, 63'b0} + {1'b0, cexp[10:0], 52'b0} + csig;
        else
            cpack = {32'b0, ({cmd.sign, 31'b0} + {1'b0, cexp[7:0], 23'b0} + csig[31:0])};

        case (cmd.op)
            OP_ADD:
            begin
                s1_fin_next = 1'b0;
                if (!cmd.sub && s129[128])
                begin
                    s1_v_next   = {1'b1, s129[127:65], s129[64], 62'b0, (s129[63:0] != '0)};
                    s1_exp_next = cmd.exp + 18'd1;
                end
                else
                    s1_v_next = s129[127:0];
            end
            OP_MUL:
            begin
                s1_fin_next = 1'b0;
            end
            OP_CVS, OP_CVD:
            begin
                if (crange)
                    s1_res_next.result_significand = cpack;
                else
                    s1_res_next.deferred = 1'b1;
            end
            OP_ZERO:
            begin
                s1_res_next.result_sign_exponent = (rc == RC_DOWN) ? 16'h8000 : 16'h0;
            end
            default:
            begin
                s1_res_next.deferred = 1'b1;
            end
        endcase
    end

    // ---------------- stage 2 ----------------
    logic         s2_valid_reg, s2_fin_reg, s2_sign_reg;
    result_t      s2_res_reg;
    logic [127:0] s2_v_reg, s2_v_next;
    logic [7:0]   s2_lz_reg, s2_lz_next;
    logic [17:0]  s2_exp_reg;

    always_comb
    begin
        if (s1_mul_reg)
        begin
            s2_v_next  = s1_v_reg + {32'b0, s1_p01_reg, 32'b0} + {32'b0, s1_p10_reg, 32'b0};
            s2_lz_next = {7'b0, !s2_v_next[127]};
        end
        else
        begin
            s2_v_next  = s1_v_reg;
            s2_lz_next = lead_zeros128(s1_v_reg);
        end
    end

    // ---------------- stage 3 ----------------
    logic         s3_valid_reg, s3_fin_reg, s3_sign_reg;
    result_t      s3_res_reg, s3_res_next;
    logic [127:0] s3_v_reg;
    logic [17:0]  s3_exp_reg;

    always_comb
    begin
        s3_res_next = s2_res_reg;
        if (!s2_fin_reg && s2_lz_reg[7])
            s3_res_next.deferred = 1'b1;
    end

    // ---------------- stage 4: round ----------------
    result_t      res_next;
    logic [63:0]  sig, extra, mask, half, inc, s, bits, m2, r;
    logic [64:0]  sum;
    logic [17:0]  e;
    logic         near, away, rinc;

    always_comb
    begin
        sig   = s3_v_reg[127:64];
        extra = s3_v_reg[63:0];
        e     = s3_exp_reg;
        near  = (rc == RC_NEAR);
        away  = s3_sign_reg ? (rc == RC_DOWN) : (rc == RC_UP);
        mask  = (pc == PC_SINGLE) ? 64'h0000_00FF_FFFF_FFFF : 64'h7FF;
        half  = (pc == PC_SINGLE) ? 64'h0000_0080_0000_0000 : 64'h400;
        s     = sig | {63'b0, (extra != '0)};
        bits  = s & mask;
        inc   = near ? half : (away ? mask : 64'h0);
        rinc  = near ? extra[63] : ((extra != '0) && away);
        sum   = '0;
        r     = sig;
        m2    = mask;
        if (pc == PC_EXT)
        begin
            sum = {1'b0, sig} + 65'd1;
            if (rinc)
            begin
                if (sum[64])
                begin
                    e = e + 18'd1;
                    r = TOP64;
                end
                else if (near && (extra[62:0] == '0))
                    r = {sum[63:1], 1'b0};
                else
                    r = sum[63:0];
            end
        end
        else
        begin
            sum = {1'b0, s} + {1'b0, inc};
            if (sum[64])
            begin
                e = e + 18'd1;
                r = TOP64;
            end
            else
                r = sum[63:0];
            if (near && (bits == half))
                m2 = mask | (mask + 64'd1);
            r = r & ~m2;
        end

        res_next = s3_res_reg;
        if (!s3_fin_reg)
        begin
            if (s3_exp_reg[17] || (s3_exp_reg == '0) || (s3_exp_reg > EXP_TOP)
                || (pc == PC_RSVD))
                res_next = '{deferred: 1'b1, result_significand: '0,
                             result_sign_exponent: '0};
            else
                res_next = '{deferred: 1'b0, result_significand: r,
                             result_sign_exponent: {s3_sign_reg, e[14:0]}};
        end
    end

    // ---------------- registers ----------------
    logic    done_reg;
    result_t result_reg;

    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fin_reg  <= s1_fin_next;
        s1_mul_reg  <= (cmd.op == OP_MUL);
        s1_sign_reg <= cmd.sign;
        s1_res_reg  <= s1_res_next;
        s1_v_reg    <= s1_v_next;
        s1_p01_reg  <= {32'b0, cmd.x[31:0]} * {32'b0, cmd.y[63:32]};
        s1_p10_reg  <= {32'b0, cmd.x[63:32]} * {32'b0, cmd.y[31:0]};
        s1_exp_reg  <= s1_exp_next;

        s2_fin_reg  <= s1_fin_reg;
        s2_sign_reg <= s1_sign_reg;
        s2_res_reg  <= s1_res_reg;
        s2_v_reg    <= s2_v_next;
        s2_lz_reg   <= s2_lz_next;
        s2_exp_reg  <= s1_exp_reg;

        s3_fin_reg  <= s2_fin_reg || s2_lz_reg[7];
        s3_sign_reg <= s2_sign_reg;
        s3_res_reg  <= s3_res_next;
        s3_v_reg    <= s2_v_reg << s2_lz_reg[6:0];
        s3_exp_reg  <= s2_exp_reg - {10'b0, s2_lz_reg};

        result_reg  <= res_next;
    end

endmodule

[rtl/extended_float_fast_path_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_float_fast_path_unit_core
// Fast path for 80-bit extended add, subtract, multiply and conversion.
//
//   channel   signals                              direction
//   command   start, busy, item                    in (busy back)
//   result    done, result                         out, one-cycle strobe
//   config    cfg_valid, cfg_ready, cfg_index,     in (ready back)
//             cfg_data
//
// One transaction per cycle while busy is low; the result strobes after the
// queue and the four back-end stages (align/add or partial products, sum and
// leading-zero count, normalize shift, round).
// Reset clears the queue and stage valid bits; config resets to nearest
// rounding and extended precision. The receiver cannot stall, so the queue
// drains every cycle and busy stays low in normal use.
// ----------------------------------------------------------------------------
module extended_float_fast_path_unit_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  efpu_pkg::item_t   item,
    output logic              done,
    output efpu_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [1:0]        cfg_data
);
    import efpu_pkg::*;

    logic [1:0] rc_reg, pc_reg;
    logic       push, full, q_valid;
    cmd_t       cmd, head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= 2'd0;
            pc_reg <= 2'd3;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_RC)
                rc_reg <= cfg_data;
            else if (cfg_index == CFG_PC)
                pc_reg <= cfg_data;
        end
    end

    efpu_front u_front (
        .start (start),
        .full  (full),
        .item  (item),
        .busy  (busy),
        .push  (push),
        .cmd   (cmd)
    );

    efpu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (q_valid),
        .full      (full),
        .valid     (q_valid),
        .head      (head)
    );

    efpu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .cmd      (head),
        .rc       (rc_reg),
        .pc       (pc_reg),
        .done     (done),
        .result   (result)
    );

endmodule

[rtl/efpu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpu_checker
// Port-level checks on latency and deferred results.
// ----------------------------------------------------------------------------
module efpu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input efpu_pkg::result_t result
);

    // every accepted transaction strobes a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("missing result strobe");

    // no result strobe without an earlier accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("unexpected result strobe");

    // deferred results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.deferred) |->
            (result.result_significand == '0) && (result.result_sign_exponent == '0))
        else $error("deferred result not cleared");

endmodule

bind extended_float_fast_path_unit_core efpu_checker u_efpu_checker (.*);

[tb/sv/efpu_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efpu_scoreboard
// Watches the command, config and result channels of the extended float
// fast-path unit. It predicts each result from its own copy of the rounding
// and precision settings and compares every result strobe in order.
// ----------------------------------------------------------------------------
module efpu_scoreboard
    import efpu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    done,
    input  result_t result,
    input  logic    cfg_valid,
    input  logic    cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data,
    output int      errors,
    output int      pending,
    output int      checked,
    output int      deferrals
);

    typedef struct packed {
        bit        defer;
        bit [63:0] sig;
        bit [15:0] se;
    } outcome_t;

    localparam bit [63:0] MSB = 64'h8000_0000_0000_0000;

    bit [1:0]  rc_shadow;
    bit [1:0]  pc_shadow;
    outcome_t  expected_q[$];

    function automatic outcome_t deferral();
        outcome_t o;
        o = '0;
        o.defer = 1'b1;
        return o;
    endfunction

    // Round a normalized significand plus sticky word at the current precision
    function automatic outcome_t round_ext(int expo, bit sign, bit [63:0] sig,
                                           bit [63:0] extra);
        outcome_t  o;
        bit        near, away, inc;
        bit [63:0] mask, half, step, bits;
        bit [64:0] sum;
        if (expo < 1 || expo > 32'h7FFD) return deferral();
        if (pc_shadow == PC_RSVD) return deferral();
        away = (sign == 1'b0 && rc_shadow == RC_UP) || (sign == 1'b1 && rc_shadow == RC_DOWN);
        near = (rc_shadow == RC_NEAR);
        if (pc_shadow == PC_EXT)
        begin
            inc = near ? extra[63] : (extra != 0 && away);
            if (inc)
            begin
                sig = sig + 1;
                if (sig == 0)
                begin
                    expo++;
                    sig = MSB;
                end
                else if (near && (extra << 1) == 0)
                begin
                    sig[0] = 1'b0;
                end
            end
        end
        else
        begin
            mask = (pc_shadow == PC_SINGLE) ? 64'hFF_FFFF_FFFF : 64'h7FF;
            half = (mask + 1) >> 1;
            if (extra != 0) sig[0] = 1'b1;
            step = near ? half : (away ? mask : 64'd0);
            bits = sig & mask;
            sum = {1'b0, sig} + {1'b0, step};
            sig = sum[63:0];
            if (sum[64])
            begin
                expo++;
                sig = MSB;
            end
            if (near && (bits << 1) == mask + 1) mask = mask | (mask + 1);
            sig = sig & ~mask;
        end
        o.defer = 1'b0;
        o.sig = sig;
        o.se = {sign, expo[14:0]};
        return o;
    endfunction

    function automatic bit usable(bit [14:0] e, bit [63:0] s);
        return e != 0 && e != 15'h7FFF && s[63];
    endfunction

    function automatic outcome_t product(item_t it);
        bit [14:0]  ea, eb;
        bit [127:0] p;
        bit [63:0]  hi, lo;
        int         expo;
        ea = it.a_sign_exponent[14:0];
        eb = it.b_sign_exponent[14:0];
        if (!usable(ea, it.a_significand) || !usable(eb, it.b_significand))
            return deferral();
        expo = int'(ea) + int'(eb) - 32'h3FFE;
        p = it.a_significand * it.b_significand;
        hi = p[127:64];
        lo = p[63:0];
        if (!hi[63])
        begin
            expo--;
            hi = {hi[62:0], lo[63]};
            lo = lo << 1;
        end
        return round_ext(expo, it.a_sign_exponent[15] ^ it.b_sign_exponent[15], hi, lo);
    endfunction

    function automatic outcome_t sum_diff(item_t it, bit negate);
        bit [15:0] ase, bse;
        bit [14:0] ea, eb;
        bit [63:0] sa, sb, sig, extra, big, lesser, lost;
        bit [64:0] wide;
        bit        sign;
        int        diff, expo, d, lz;
        outcome_t  o;
        ase = it.a_sign_exponent;
        bse = it.b_sign_exponent ^ {negate, 15'd0};
        sa = it.a_significand;
        sb = it.b_significand;
        ea = ase[14:0];
        eb = bse[14:0];
        if (!usable(ea, sa) || !usable(eb, sb)) return deferral();
        diff = int'(ea) - int'(eb);
        if (diff > 63 || diff < -63) return deferral();
        sign = ase[15];
        expo = int'(ea);
        if (ase[15] == bse[15])
        begin
            // like signs: magnitude add, at most one bit of growth
            if (diff == 0)
            begin
                wide = {1'b0, sa} + {1'b0, sb};
                extra = {wide[0], 63'd0};
                sig = {1'b1, wide[63:1]};
                return round_ext(expo + 1, sign, sig, extra);
            end
            if (diff > 0)
            begin
                big = sa; lesser = sb; d = diff;
            end
            else
            begin
                big = sb; lesser = sa; d = -diff; expo = int'(eb);
            end
            extra = lesser << (64 - d);
            sig = big + (lesser >> d);
            if (sig[63]) return round_ext(expo, sign, sig, extra);
            extra = {sig[0], 62'd0, extra != 0};
            sig = {1'b1, sig[63:1]};
            return round_ext(expo + 1, sign, sig, extra);
        end
        // unlike signs: magnitude subtract
        if (diff == 0)
        begin
            if (sa == sb)
            begin
                o = '0;
                o.se = (rc_shadow == RC_DOWN) ? 16'h8000 : 16'h0000;
                return o;
            end
            if (sa > sb) sig = sa - sb;
            else
            begin
                sig = sb - sa;
                sign = ~sign;
            end
            extra = 0;
        end
        else
        begin
            if (diff > 0)
            begin
                big = sa; lesser = sb; d = diff;
            end
            else
            begin
                big = sb; lesser = sa; d = -diff; expo = int'(eb); sign = ~sign;
            end
            lost = lesser << (64 - d);
            extra = 64'd0 - lost;
            sig = big - (lesser >> d) - (lost != 0);
        end
        if (sig == 0)
        begin
            expo -= 64;
            sig = extra;
            extra = 0;
        end
        if (sig == 0) return deferral();
        lz = 0;
        while (!sig[63 - lz]) lz++;
        expo -= lz;
        if (lz != 0)
        begin
            sig = (sig << lz) | (extra >> (64 - lz));
            extra = extra << lz;
        end
        return round_ext(expo, sign, sig, extra);
    endfunction

    function automatic outcome_t narrow(item_t it, bit to_double);
        bit [14:0] e;
        bit        sign;
        int        expo, n, limit;
        bit [63:0] val, half, away_step, step, bits, sig;
        outcome_t  o;
        e = it.a_sign_exponent[14:0];
        sign = it.a_sign_exponent[15];
        if (e == 15'h7FFF) return deferral();
        if (to_double)
        begin
            val = (it.a_significand >> 1) | it.a_significand[0];
            expo = int'(e) - 32'h3C01;
            n = 10; half = 64'h200; away_step = 64'h3FF; limit = 32'h7FC;
        end
        else
        begin
            val = (it.a_significand >> 33) | (it.a_significand[32:0] != 0);
            expo = int'(e) - 32'h3F81;
            n = 7; half = 64'h40; away_step = 64'h7F; limit = 32'hFC;
        end
        if (expo < 0 || expo > limit) return deferral();
        if (rc_shadow == RC_NEAR) step = half;
        else if ((sign == 1'b0 && rc_shadow == RC_UP) || (sign == 1'b1 && rc_shadow == RC_DOWN))
            step = away_step;
        else step = 0;
        bits = val & ((64'd1 << n) - 1);
        sig = (val + step) >> n;
        if (bits == half && rc_shadow == RC_NEAR) sig[0] = 1'b0;
        if (sig == 0) expo = 0;
        o = '0;
        if (to_double)
            o.sig = ({63'd0, sign} << 63) + (64'(expo) << 52) + sig;
        else
            o.sig = (({63'd0, sign} << 31) + (64'(expo) << 23) + sig) & 64'hFFFF_FFFF;
        return o;
    endfunction

    function automatic outcome_t predict(item_t it);
        case (it.kind)
            KIND_ADD: return sum_diff(it, 1'b0);
            KIND_SUB: return sum_diff(it, 1'b1);
            KIND_MUL: return product(it);
            KIND_CVS: return narrow(it, 1'b0);
            KIND_CVD: return narrow(it, 1'b1);
            default:  return deferral();
        endcase
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            rc_shadow <= RC_NEAR;
            pc_shadow <= PC_EXT;
            errors    <= 0;
            checked   <= 0;
            deferrals <= 0;
            expected_q.delete();
        end
        else
        begin
            // result side first; latency keeps it clear of this edge's command
            if (done)
            begin
                checked <= checked + 1;
                if (result.deferred) deferrals <= deferrals + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.deferred !== want.defer
                        || result.result_significand !== want.sig
                        || result.result_sign_exponent !== want.se)
                    begin
                        $display("%0t: mismatch expected defer=%0d sig=%h se=%h actual defer=%0d sig=%h se=%h",
                                 $time, want.defer, want.sig, want.se, result.deferred,
                                 result.result_significand, result.result_sign_exponent);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy) expected_q.push_back(predict(item));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RC) rc_shadow <= cfg_data;
                else if (cfg_index == CFG_PC) pc_shadow <= cfg_data;
            end
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the extended float fast-path unit: a directed set of corner
// operands, then random operations over every rounding/precision setting,
// with random gaps (none under round-down). The scoreboard judges each result.
// ----------------------------------------------------------------------------
module testbench;
    import efpu_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    item_t      item;
    logic       done;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [1:0] cfg_data;
    int         errors, pending, checked, deferrals;
    bit         no_gaps;
    int         sent;

    extended_float_fast_path_unit_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    efpu_scoreboard sb (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
        .pending(pending), .checked(checked), .deferrals(deferrals)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One command transaction, after a random gap unless no_gaps is set
    task automatic issue(input item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item = it;
        start = 1'b1;
        while (busy) @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    // Wait for the unit to empty out, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic item_t make(logic [2:0] k, logic [63:0] sa, logic [15:0] ea,
                                   logic [63:0] sbv, logic [15:0] eb);
        item_t it;
        it.kind = k;
        it.a_significand = sa;
        it.a_sign_exponent = ea;
        it.b_significand = sbv;
        it.b_sign_exponent = eb;
        return it;
    endfunction

    // Random operand exponent: mostly mid-range, sometimes at the edges
    function automatic logic [14:0] pick_exp(logic [2:0] k);
        case ($urandom_range(0, 9))
            0: return 15'($urandom_range(0, 3));
            1: return 15'($urandom_range(15'h7FFB, 15'h7FFF));
            2: return 15'($urandom);
            default:
                if (k == KIND_CVS) return 15'($urandom_range(15'h3F7E, 15'h4080));
                else if (k == KIND_CVD) return 15'($urandom_range(15'h3BFE, 15'h4400));
                else if (k == KIND_MUL && $urandom_range(0, 3) == 0)
                    return $urandom_range(0, 1) ? 15'($urandom_range(15'h5FF0, 15'h7FFD))
                                                : 15'($urandom_range(1, 15'h2010));
                else return 15'($urandom_range(15'h3F00, 15'h4100));
        endcase
    endfunction

    function automatic item_t random_op();
        item_t       it;
        logic [2:0]  k;
        logic [14:0] ea, eb;
        int          d;
        k = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        ea = pick_exp(k);
        d = $urandom_range(0, 4) == 0 ? $urandom_range(0, 140) - 70 : $urandom_range(0, 6) - 3;
        eb = (k == KIND_MUL) ? pick_exp(k) : 15'(int'(ea) + d);
        it = make(k, rand64(), {1'($urandom), ea}, rand64(), {1'($urandom), eb});
        // mostly normalized operands; unnormals now and then
        if ($urandom_range(0, 15) != 0) it.a_significand[63] = 1'b1;
        if ($urandom_range(0, 15) != 0) it.b_significand[63] = 1'b1;
        // near-cancellation and exact cancellation
        if (k <= KIND_SUB && $urandom_range(0, 5) == 0)
        begin
            it.b_sign_exponent[14:0] = ea;
            it.b_significand = $urandom_range(0, 1) ? it.a_significand
                                                    : it.a_significand ^ 64'($urandom_range(0, 255));
        end
        // short significands exercise exact and tie rounding
        if ($urandom_range(0, 5) == 0) it.a_significand[39:0] = 40'($urandom_range(0, 3)) << 38;
        return it;
    endfunction

    localparam logic [63:0] ONE = 64'h8000_0000_0000_0000;

    initial
    begin
        int rc, pci, n;
        logic [1:0] pc_order [4];
        pc_order = '{PC_EXT, PC_SINGLE, PC_DOUBLE, PC_RSVD};
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RC;
        cfg_data = RC_NEAR;
        no_gaps = 1'b0;
        sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners at reset settings
        issue(make(KIND_ADD, ONE, 16'h3FFF, ONE, 16'h3FFF));
        issue(make(KIND_SUB, ONE, 16'h3FFF, 64'hC000_0000_0000_0000, 16'h3FFE));
        issue(make(KIND_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 16'h4000, 64'hFFFF_FFFF_FFFF_FFFF, 16'h4000));
        issue(make(KIND_ADD, ONE, 16'h3FFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hBFC0));
        issue(make(KIND_ADD, ONE, 16'h3FFF, ONE, 16'h3FBF));
        issue(make(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFD, ONE, 16'h3FFF));
        issue(make(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFD,
                   64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFD));
        issue(make(KIND_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFE,
                   64'hFFFF_FFFF_FFFF_FFFF, 16'h3FFF));
        issue(make(KIND_MUL, ONE, 16'h0001, ONE, 16'h0001));
        issue(make(KIND_MUL, ONE, 16'h7FFE, ONE, 16'h7FFE));
        issue(make(KIND_MUL, 64'h8000_0000_0000_0001, 16'h3FFF, 64'hC000_0000_0000_0001, 16'hBFFF));
        issue(make(KIND_ADD, ONE, 16'h0000, ONE, 16'h3FFF));
        issue(make(KIND_ADD, ONE, 16'h7FFF, ONE, 16'h3FFF));
        issue(make(KIND_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 16'h3FFF, ONE, 16'h3FFF));
        issue(make(KIND_CVS, ONE, 16'h3FFF, '0, '0));
        issue(make(KIND_CVS, 64'hFFFF_FFFF_FFFF_FFFF, 16'hC07D, '0, '0));
        issue(make(KIND_CVS, ONE, 16'h3F80, '0, '0));
        issue(make(KIND_CVS, 64'h0000_0000_0000_0001, 16'h3F81, '0, '0));
        issue(make(KIND_CVD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h43FC, '0, '0));
        issue(make(KIND_CVD, ONE, 16'h43FE, '0, '0));
        issue(make(KIND_CVD, 64'h8000_0000_0000_0400, 16'hBC01, '0, '0));
        issue(make(KIND_CVD, ONE, 16'hFFFF, '0, '0));
        issue(make(3'd7, rand64(), 16'hFFFF, rand64(), 16'hFFFF));
        issue(make(3'd5, '0, '0, '0, '0));

        // random operations under every rounding and precision pairing
        for (pci = 0; pci < 4; pci++)
        begin
            write_reg(CFG_PC, pc_order[pci]);
            for (rc = 3; rc >= 0; rc--)
            begin
                write_reg(CFG_RC, 2'(rc));
                no_gaps = (rc == 1);
                for (n = 0; n < 64; n++)
                begin
                    issue(random_op());
                    // hold off once until the unit has drained
                    if (pci == 1 && rc == 2 && n == 30)
                    begin
                        @(negedge clk);
                        start = 1'b0;
                        while (pending != 0) @(negedge clk);
                    end
                end
            end
        end
        @(negedge clk);
        start = 1'b0;
        no_gaps = 1'b0;

        n = 0;
        while (pending != 0 && n < 1000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (10) @(negedge clk);
        $display("Sent %0d operations over 16 rounding/precision settings; %0d results checked,",
                 sent, checked);
        $display("%0d of them deferred to the slow path.", deferrals);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
